/* sv/assert_macros.svh */
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define FIS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is held.
`define FIS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fis_pkg.sv */
package fis_pkg;

  localparam int COORD_W = 24;
  localparam int CNT_W   = 6;

  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_OBSTACLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] span_end;
    logic [COORD_W-1:0] range_a;
    logic [COORD_W-1:0] range_b;
  } fis_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] best_start;
    logic [COORD_W-1:0] best_stop;
    logic [CNT_W-1:0]   window_count;
    logic               has_window;
    logic               overflowed;
  } fis_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } fis_win_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic setup;
    logic walk;
    logic split;
    logic commit;
  } fis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic list_empty;
    logic last;
    logic split_go;
  } fis_stat_t;

endpackage

/* sv/fis_dp.sv */
module fis_dp #(
  parameter int MAX_WINDOWS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fis_pkg::fis_in_t   in_data,
  input  fis_pkg::fis_cmd_t  cmd,
  output fis_pkg::fis_stat_t stat,
  output fis_pkg::fis_out_t  out_data
);
  import fis_pkg::*;

  localparam int IW    = $clog2(MAX_WINDOWS);
  localparam int NW    = $clog2(MAX_WINDOWS + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [NW:0] MAX_V = (NW + 1)'(MAX_WINDOWS);

  // Two banks: the current list is read from one, the new list written to the other.
  fis_win_t mem [DEPTH];

  logic               kind_r;
  logic [COORD_W-1:0] span_r;
  logic [COORD_W-1:0] a_r;
  logic [COORD_W-1:0] b_r;
  logic               empty_r;
  logic               bank_r;
  logic [NW-1:0]      count_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      i_r;
  logic               ovf_r;
  fis_win_t           rd_r;
  fis_win_t           up_r;

  logic               sa_vld_r;
  fis_win_t           sa_r;
  logic               sb_vld_r;
  fis_win_t           sb_r;
  logic [COORD_W-1:0] sb_w_r;
  logic               found_r;
  fis_win_t           best_r;
  logic [COORD_W-1:0] best_w_r;

  logic               a_le_lo, b_ge_hi, a_lt_hi, b_gt_lo;
  logic               is_cover, is_split, is_top, is_bottom;
  logic               room, last;
  logic [NW:0]        room_sum;
  logic [NW-1:0]      i_inc;
  logic               wr_en, rd_en;
  fis_win_t           wr_d;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [COORD_W-1:0] ca, cb;
  logic [31:0]        cnt_ext;

  assign ca = (in_data.range_a > span_r) ? span_r : in_data.range_a;
  assign cb = (in_data.range_b > span_r) ? span_r : in_data.range_b;

  assign a_le_lo = a_r <= rd_r.lo;
  assign b_ge_hi = b_r >= rd_r.hi;
  assign a_lt_hi = a_r < rd_r.hi;
  assign b_gt_lo = b_r > rd_r.lo;

  assign is_cover  = !empty_r && a_le_lo && b_ge_hi;
  assign is_split  = !empty_r && !a_le_lo && !b_ge_hi;
  assign is_top    = !empty_r && !a_le_lo && a_lt_hi;
  assign is_bottom = !empty_r && b_gt_lo && !b_ge_hi;

  assign room_sum = {1'b0, n_r} + {1'b0, count_r - i_r};
  assign room     = room_sum < MAX_V;
  assign last     = i_r == (count_r - NW'(1));
  assign i_inc    = i_r + NW'(1);

  always_comb begin
    wr_en = 1'b0;
    wr_d  = '0;
    if (cmd.setup && kind_r == KIND_START) begin
      wr_en = span_r != '0;
      wr_d  = '{lo: '0, hi: span_r};
    end else if (cmd.walk) begin
      if (is_cover) begin
        wr_en = 1'b0;
      end else if (is_split || is_top) begin
        wr_en = 1'b1;
        wr_d  = '{lo: rd_r.lo, hi: a_r};
      end else if (is_bottom) begin
        wr_en = 1'b1;
        wr_d  = '{lo: b_r, hi: rd_r.hi};
      end else begin
        wr_en = 1'b1;
        wr_d  = rd_r;
      end
    end else if (cmd.split) begin
      wr_en = 1'b1;
      wr_d  = up_r;
    end
  end

  // The new list always begins at entry zero, and during setup the fill
  // count still holds the size of the previous list.
  assign wr_addr = {~bank_r, cmd.setup ? {IW{1'b0}} : n_r[IW-1:0]};
  assign rd_en   = (cmd.setup && kind_r == KIND_OBSTACLE) || (cmd.walk && !last);
  assign rd_addr = cmd.walk ? {bank_r, i_inc[IW-1:0]} : {bank_r, {IW{1'b0}}};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_d;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= in_data.kind;
      a_r    <= ca;
      b_r    <= cb;
    end else if (cmd.setup && kind_r == KIND_OBSTACLE) begin
      a_r     <= (a_r > b_r) ? b_r : a_r;
      b_r     <= (a_r > b_r) ? a_r : b_r;
      empty_r <= a_r == b_r;
    end
    if (cmd.walk) begin
      up_r <= '{lo: b_r, hi: rd_r.hi};
    end
    sa_r   <= wr_d;
    sb_r   <= sa_r;
    sb_w_r <= sa_r.hi - sa_r.lo;
  end

  // List control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= '0;
      bank_r   <= 1'b0;
      count_r  <= '0;
      n_r      <= '0;
      i_r      <= '0;
      ovf_r    <= 1'b0;
      sa_vld_r <= 1'b0;
      sb_vld_r <= 1'b0;
    end else begin
      if (cmd.cap && in_data.kind == KIND_START) begin
        span_r <= in_data.span_end;
      end
      if (cmd.setup) begin
        n_r <= NW'(wr_en);
        i_r <= '0;
        if (kind_r == KIND_START) begin
          ovf_r <= 1'b0;
        end
      end else begin
        if (wr_en) begin
          n_r <= n_r + NW'(1);
        end
        if ((cmd.walk && !(is_split && room)) || cmd.split) begin
          i_r <= i_inc;
        end
        if (cmd.walk && is_split && !room) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count_r <= n_r;
        bank_r  <= ~bank_r;
      end
      sa_vld_r <= wr_en;
      sb_vld_r <= sa_vld_r;
    end
  end

  // Widest window: strict compare keeps the first one on a tie.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.setup) begin
      found_r <= 1'b0;
    end else if (sb_vld_r && (!found_r || sb_w_r > best_w_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      best_r   <= '0;
      best_w_r <= '0;
    end else if (sb_vld_r && (!found_r || sb_w_r > best_w_r)) begin
      best_r   <= sb_r;
      best_w_r <= sb_w_r;
    end
  end

  assign cnt_ext = 32'(count_r);

  assign stat.is_start   = kind_r == KIND_START;
  assign stat.list_empty = count_r == '0;
  assign stat.last       = last;
  assign stat.split_go   = is_split && room;

  assign out_data.best_start   = best_r.lo;
  assign out_data.best_stop    = best_r.hi;
  assign out_data.window_count = cnt_ext[CNT_W-1:0];
  assign out_data.has_window   = found_r;
  assign out_data.overflowed   = ovf_r;

endmodule

/* sv/fis_ctrl.sv */
module fis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fis_pkg::fis_stat_t stat,
  output fis_pkg::fis_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import fis_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = (stat.is_start || stat.list_empty) ? S_COMMIT : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.split_go) begin
          state_nxt = S_SPLIT;
        end else if (stat.last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = stat.last ? S_COMMIT : S_WALK;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_REPORT;

endmodule

/* sv/free_interval_subtractor_core.sv */
// Free interval subtractor. Holds an ordered list of free windows on a span
// and reports the widest one after every beat. A beat is taken at a rising
// edge where start is high and busy is low; busy then stays high until the
// result has been shown. The result is on out_data for exactly one cycle,
// marked by out_valid, and the receiver cannot stall it, so it must be
// captured in that cycle. A start beat passes through setup, commit, drain
// and report before the block is idle again, with the result strobed in
// the report state. An obstacle beat on a non-empty list also walks the
// list between setup and commit: the walk reads one stored window per
// cycle through the single read port of the window memory and writes at
// most one piece per cycle, but a split that keeps both pieces holds the
// walk for an extra split state that writes the upper piece.
module free_interval_subtractor_core #(
  parameter int MAX_WINDOWS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fis_pkg::fis_in_t  in_data,
  output logic              out_valid,
  output fis_pkg::fis_out_t out_data
);
  import fis_pkg::*;

  // The controller sequences setup, the window walk, the commit of the new
  // list and a drain state that lets the widest-window pipeline settle.
  fis_cmd_t  cmd;
  fis_stat_t stat;

  fis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath keeps the list in two banks of one memory and rebuilds it
  // into the other bank on every beat, then swaps banks.
  fis_dp #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* sv/fis_checker.sv */
`include "assert_macros.svh"

module fis_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input fis_pkg::fis_out_t out_data
);
  import fis_pkg::*;

  logic rep_none;
  logic rep_some;
  logic rep_zero;
  logic rep_ordered;

  assign rep_none    = out_valid && !out_data.has_window;
  assign rep_some    = out_valid && out_data.has_window;
  assign rep_zero    = (out_data.best_start == '0) && (out_data.best_stop == '0);
  assign rep_ordered = out_data.best_start < out_data.best_stop;

  // A result only appears while a beat is in work.
  `FIS_ASSERT_IMP(a_strobe_in_work, clk, rst_n, out_valid, busy, "result outside a beat")

  // One result per beat: strobes never run back to back.
  `FIS_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result repeated")

  // An accepted beat makes the block busy.
  `FIS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "beat not taken")

  // No window means a zero report; a reported window has positive width.
  `FIS_ASSERT_IMP(a_empty_zero, clk, rst_n, rep_none, rep_zero, "empty report not zero")
  `FIS_ASSERT_IMP(a_width_pos, clk, rst_n, rep_some, rep_ordered, "window has no width")

endmodule

bind free_interval_subtractor_core fis_checker u_fis_checker (.*);

/* dv/fis_tb_pkg.sv */
package fis_tb_pkg;

  import fis_pkg::*;

  localparam int WINDOW_SLOTS = 32;
  localparam int REPORT_LIMIT = 10;

  // Tracks the free windows of the span and the report due after each beat.
  class window_tracker;

    logic [COORD_W-1:0] win_lo [WINDOW_SLOTS];
    logic [COORD_W-1:0] win_hi [WINDOW_SLOTS];
    int                 n_win = 0;
    logic [COORD_W-1:0] span = '0;
    bit                 dropped_split = 1'b0;
    fis_out_t           expected_reports [$];
    int unsigned        mismatches = 0;

    function void subtract_obstacle(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] nlo [WINDOW_SLOTS];
      logic [COORD_W-1:0] nhi [WINDOW_SLOTS];
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      int                 n;
      if (a > span) a = span;
      if (b > span) b = span;
      if (a == b) return;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      n = 0;
      for (int i = 0; i < n_win; i++) begin
        lo = win_lo[i];
        hi = win_hi[i];
        if (a <= lo && b >= hi) begin
          continue;
        end else if (a > lo && b < hi) begin
          nlo[n] = lo;
          nhi[n] = a;
          n++;
          // The upper piece only survives if the remaining windows still fit.
          if (n + (n_win - i - 1) < WINDOW_SLOTS) begin
            nlo[n] = b;
            nhi[n] = hi;
            n++;
          end else begin
            dropped_split = 1'b1;
          end
        end else if (a > lo && a < hi) begin
          nlo[n] = lo;
          nhi[n] = a;
          n++;
        end else if (b > lo && b < hi) begin
          nlo[n] = b;
          nhi[n] = hi;
          n++;
        end else begin
          nlo[n] = lo;
          nhi[n] = hi;
          n++;
        end
      end
      for (int i = 0; i < n; i++) begin
        win_lo[i] = nlo[i];
        win_hi[i] = nhi[i];
      end
      n_win = n;
    endfunction

    function fis_out_t widest_report();
      fis_out_t           rep;
      logic [COORD_W-1:0] best_w;
      logic [COORD_W-1:0] w;
      rep = '0;
      best_w = '0;
      for (int i = 0; i < n_win; i++) begin
        w = win_hi[i] - win_lo[i];
        if (!rep.has_window || w > best_w) begin
          rep.has_window = 1'b1;
          best_w = w;
          rep.best_start = win_lo[i];
          rep.best_stop = win_hi[i];
        end
      end
      rep.window_count = n_win[CNT_W-1:0];
      rep.overflowed = dropped_split;
      return rep;
    endfunction

    function void note_beat(fis_in_t beat);
      if (beat.kind == KIND_START) begin
        span = beat.span_end;
        dropped_split = 1'b0;
        n_win = 0;
        if (span != '0) begin
          win_lo[0] = '0;
          win_hi[0] = span;
          n_win = 1;
        end
      end else begin
        subtract_obstacle(beat.range_a, beat.range_b);
      end
      expected_reports.insert(expected_reports.size(), widest_report());
    endfunction

    function void check_result(fis_out_t got);
      fis_out_t exp_rep;
      bit       bad;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: result with nothing expected, got start=%0d stop=%0d cnt=%0d",
                   got.best_start, got.best_stop, got.window_count);
        return;
      end
      exp_rep = expected_reports.pop_front();
      bad = 1'b0;
      if (got.best_start !== exp_rep.best_start) bad = 1'b1;
      if (got.best_stop !== exp_rep.best_stop) bad = 1'b1;
      if (got.window_count !== exp_rep.window_count) bad = 1'b1;
      if (got.has_window !== exp_rep.has_window) bad = 1'b1;
      if (got.overflowed !== exp_rep.overflowed) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $write("mismatch: expected %0d..%0d cnt=%0d has=%0b ovf=%0b, ",
                 exp_rep.best_start, exp_rep.best_stop, exp_rep.window_count,
                 exp_rep.has_window, exp_rep.overflowed);
          $display("got %0d..%0d cnt=%0d has=%0b ovf=%0b",
                   got.best_start, got.best_stop, got.window_count,
                   got.has_window, got.overflowed);
        end
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

  endclass

endpackage

/* dv/tb_top.sv */
module tb_top;

  import fis_pkg::*;
  import fis_tb_pkg::*;

  // Even with the slowest beats and the longest sender gaps, a couple of
  // thousand beats fit well inside the limit, which leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_BEATS = 2000;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  fis_in_t  in_data = '0;
  logic     out_valid;
  fis_out_t out_data;

  window_tracker sb;
  int unsigned   cycles = 0;
  int unsigned   beats_sent = 0;
  int unsigned   burst_left = 0;
  // Span of the most recent start beat, used only to aim obstacle ranges.
  logic [COORD_W-1:0] cur_span = '0;

  free_interval_subtractor_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The result is strobed for exactly one cycle and cannot be held off, so
  // every edge with out_valid high is a result beat that must be checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic logic [COORD_W-1:0] rnd_coord();
    return COORD_W'($urandom_range(0, COORD_MAX));
  endfunction

  // Unused fields carry random values so that the block is seen to ignore them.
  function automatic fis_in_t make_start(logic [COORD_W-1:0] span_end);
    fis_in_t beat;
    beat.kind = KIND_START;
    beat.span_end = span_end;
    beat.range_a = rnd_coord();
    beat.range_b = rnd_coord();
    return beat;
  endfunction

  function automatic fis_in_t make_obstacle(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    fis_in_t beat;
    beat.kind = KIND_OBSTACLE;
    beat.span_end = rnd_coord();
    beat.range_a = a;
    beat.range_b = b;
    return beat;
  endfunction

  // A short range somewhere on the span; hole_div sets how narrow it is
  // relative to the span. Either order of the ends is used.
  function automatic fis_in_t make_hole(logic [COORD_W-1:0] s, int unsigned hole_div);
    int unsigned a;
    int unsigned b;
    a = $urandom_range(0, s);
    b = a + $urandom_range(1, s / hole_div + 1);
    if (b > COORD_MAX) b = COORD_MAX;
    if ($urandom_range(0, 1) == 1)
      return make_obstacle(COORD_W'(b), COORD_W'(a));
    return make_obstacle(COORD_W'(a), COORD_W'(b));
  endfunction

  // Obstacle mix for ordinary sequences: mostly ranges on the span, with
  // out-of-span, empty, edge-touching and oversized ranges mixed in.
  function automatic fis_in_t pick_obstacle(logic [COORD_W-1:0] s);
    logic [COORD_W-1:0] a;
    case ($urandom_range(0, 9))
      0: begin
        return make_obstacle(rnd_coord(), rnd_coord());
      end
      1: begin
        a = COORD_W'($urandom_range(0, s));
        return make_obstacle(a, a);
      end
      6, 7: begin
        return make_hole(s, 32);
      end
      8: begin
        a = ($urandom_range(0, 1) == 1) ? s : '0;
        return make_obstacle(a, COORD_W'($urandom_range(0, s)));
      end
      9: begin
        return make_obstacle(COORD_W'($urandom_range(0, s)),
                             COORD_W'($urandom_range(s, COORD_MAX)));
      end
      default: begin
        return make_obstacle(COORD_W'($urandom_range(0, s)), COORD_W'($urandom_range(0, s)));
      end
    endcase
  endfunction

  // Presents one beat and returns at the edge that accepts it. The sender
  // works in bursts: inside a burst start stays high from beat to beat, and
  // between bursts it may drop for a random number of cycles. A gap can end on
  // any cycle of the block's work, including while it is still busy.
  task automatic send_beat(input fis_in_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (beat.kind == KIND_START) cur_span = beat.span_end;
    in_data <= beat;
    start <= 1'b1;
    // busy read right after the edge still holds its pre-edge value, which
    // is what the block saw when it decided whether to take the beat.
    do @(posedge clk); while (busy);
    sb.note_beat(beat);
    beats_sent++;
  endtask

  task automatic run_directed();
    // Obstacle before any span exists: the list stays empty.
    send_beat(make_obstacle(24'd10, 24'd20));
    // A zero span end gives no window at all.
    send_beat(make_start('0));
    send_beat(make_obstacle('0, COORD_MAX));
    // Full-width span wiped out by a reversed range covering it exactly.
    send_beat(make_start(COORD_MAX));
    send_beat(make_obstacle(COORD_MAX, '0));
    // Split in the middle of the widest span, then trims at both ends.
    send_beat(make_start(COORD_MAX));
    send_beat(make_obstacle(24'h800000, 24'h7FFFFF));
    send_beat(make_obstacle(24'h000000, 24'h000001));
    send_beat(make_obstacle(24'hFFFFFE, COORD_MAX));
    // Equal-width windows after a split: the first one must be reported.
    send_beat(make_start(24'd1000));
    send_beat(make_obstacle(24'd400, 24'd600));
    // Empty range, and a range that becomes empty once clamped to the span.
    send_beat(make_obstacle(24'd300, 24'd300));
    send_beat(make_obstacle(24'd2000, 24'd5000));
    // Range running past the span end trims the top window.
    send_beat(make_obstacle(24'd900, 24'd5000));
    // Range matching a window exactly removes it.
    send_beat(make_obstacle('0, 24'd400));
    // Range straddling a window's lower edge trims its bottom, then a reversed range splits it.
    send_beat(make_obstacle(24'd599, 24'd601));
    send_beat(make_obstacle(24'd700, 24'd650));
    // Smallest spans: a one-unit window removed, then an empty range, a top trim, a removal.
    send_beat(make_start(24'd1));
    send_beat(make_obstacle(24'd1, '0));
    send_beat(make_start(24'd2));
    send_beat(make_obstacle(24'd1, 24'd1));
    send_beat(make_obstacle(24'd1, 24'd2));
    send_beat(make_obstacle('0, 24'd1));
  endtask

  // Random sequences, most of them opened by a start beat. Fragmenting sequences
  // punch many narrow holes into a wide span so the list fills up and
  // further splits lose their upper piece; narrow-span sequences pile up
  // equal widths and boundary hits; noise is fully random beats.
  task automatic run_random();
    int unsigned n_obst;
    logic [COORD_W-1:0] s;
    while (beats_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 1) send_beat(make_obstacle(rnd_coord(), rnd_coord()));
            else send_beat(make_start(rnd_coord()));
          end
        end
        1, 2: begin
          s = ($urandom_range(0, 3) == 0) ? COORD_MAX : COORD_W'($urandom_range(24'h010000, COORD_MAX));
          send_beat(make_start(s));
          n_obst = $urandom_range(34, 45);
          repeat (n_obst) begin
            if ($urandom_range(0, 7) == 0) send_beat(pick_obstacle(s));
            else send_beat(make_hole(s, 256));
          end
        end
        9: begin
          s = COORD_W'($urandom_range(1, 20));
          send_beat(make_start(s));
          repeat ($urandom_range(1, 10)) send_beat(pick_obstacle(s));
        end
        default: begin
          case ($urandom_range(0, 5))
            0: s = '0;
            1: s = COORD_MAX;
            2: s = COORD_W'($urandom_range(1, 64));
            default: s = rnd_coord();
          endcase
          send_beat(make_start(s));
          repeat ($urandom_range(1, 12)) send_beat(pick_obstacle(cur_span));
        end
      endcase
    end
  endtask

  initial begin
    sb = new;
    // Synchronous reset is held from time zero, then released once for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    start <= 1'b0;
    // Every beat yields exactly one result; wait for the last, then allow a
    // few extra cycles for any stray strobe to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
